FILE: hw/rtl/nsm_pkg.sv
`default_nettype none
package nsm_pkg;

  // Compare window and needle store depth (equal to the longest needle)
  localparam int unsigned WIN = 30;
  // Append limits for needle and haystack
  localparam logic [4:0] NEEDLE_LIMIT = 5'd27;
  localparam logic [6:0] HAY_LIMIT    = 7'd91;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LOW_P = 8'h70;
  localparam logic [7:0] CH_LOW_L = 8'h6C;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_LOW_S = 8'h73;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Character line, element 0 holds the newest character
  typedef logic [WIN-1:0][7:0] win_t;

  // Normalized input word
  typedef struct packed {
    logic       vld;
    logic       hay;
    logic       last;
    logic       take;
    logic       plus;
    logic [7:0] chr;
  } norm_t;

endpackage
`default_nettype wire

FILE: hw/rtl/nsm_norm.sv
`default_nettype none
module nsm_norm
  import nsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       req_type,
  input  wire logic [7:0] char_code,
  input  wire logic       has_char,
  input  wire logic       last_char,
  output norm_t           item_r
);

  norm_t item_nxt;
  logic  drop;
  logic  upper;

  // Classify the byte: drop separators, flag plus, lower letters
  always_comb begin
    drop  = (char_code == CH_SPACE) || (char_code == CH_DASH) || (char_code == CH_UNDER);
    upper = (char_code >= CH_UP_A) && (char_code <= CH_UP_Z);
    item_nxt.vld  = accept;
    item_nxt.hay  = req_type;
    item_nxt.last = last_char;
    item_nxt.take = has_char && (char_code != 8'h00) && !drop;
    item_nxt.plus = (char_code == CH_PLUS);
    item_nxt.chr  = upper ? (char_code + CASE_OFS) : char_code;
  end

  // Hold the decoded word for the update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= item_nxt.vld;
    end
    item_r.hay  <= item_nxt.hay;
    item_r.last <= item_nxt.last;
    item_r.take <= item_nxt.take;
    item_r.plus <= item_nxt.plus;
    item_r.chr  <= item_nxt.chr;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/normalized_substring_match_core.sv
// Normalized substring match.
// A needle string and then a haystack string stream in, one byte per input
// word (req_type 0 = needle, 1 = haystack, last_char closes the string).
// Separators are dropped, '+' expands to "plus" and letters are lowered
// before the compare. A haystack word with last_char set yields one result
// word on the out_ channel: out_match is 1 when the needle occurs in the
// haystack and both are non-empty.
// Throughput: one input word per cycle while in_stall is low. The input word
// is decoded into a register, then the window shift and all four possible
// needle compares of a "plus" expansion update the state in the next cycle.
// A result passes from the decoded word register into the output buffer;
// out_valid rises when it reaches the head register.
// Results go to a two-entry output buffer, so input words keep flowing while
// a result waits; in_stall rises only when buffered and in-flight results
// would fill it, and it drops in the cycle after a result is taken.
// Reset clears the lengths, flags and the output buffer; the character
// stores are left as they are and are never read before being written.
`default_nettype none
module normalized_substring_match_core
  import nsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_has_char,
  input  wire logic       in_last_char,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_match
);

  norm_t      item_r;
  logic       accept;
  logic       stg_res;

  win_t       needle_r, needle_nxt;
  win_t       win_r, win_nxt;
  logic [4:0] nlen_r, nlen_nxt;
  logic [6:0] hlen_r, hlen_nxt;
  logic       closed_r, closed_nxt;
  logic       found_r, found_nxt;

  logic       push;
  logic       push_match;
  logic       out_v_r, out_m_r;
  logic       sk_v_r, sk_m_r;
  logic       pop;

  // Tail compare of the newest nl window characters against the needle
  function automatic logic tail_hit(win_t w, win_t nd, logic [4:0] nl, logic [6:0] hl);
    logic eq;
    eq = 1'b1;
    for (int j = 0; j < WIN; j++) begin
      if ((5'(j) < nl) && (w[j] != nd[j])) eq = 1'b0;
    end
    return eq && (nl != 5'd0) && (hl >= {2'b00, nl});
  endfunction

  // Accept while the output buffer can take every result in flight
  assign stg_res  = item_r.vld && item_r.hay && item_r.last;
  assign in_stall = (out_v_r && sk_v_r) || ((out_v_r || sk_v_r) && stg_res);
  assign accept   = in_valid && !in_stall;

  nsm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req_type),
    .char_code (in_char_code),
    .has_char  (in_has_char),
    .last_char (in_last_char),
    .item_r    (item_r)
  );

  // Update needle, window, lengths and the hit flag for one word
  always_comb begin
    win_t w1, w2, w3, w4;
    logic h1, h2, h3, h4;
    w1 = {win_r[WIN-2:0], CH_LOW_P};
    w2 = {win_r[WIN-3:0], CH_LOW_P, CH_LOW_L};
    w3 = {win_r[WIN-4:0], CH_LOW_P, CH_LOW_L, CH_LOW_U};
    w4 = {win_r[WIN-5:0], CH_LOW_P, CH_LOW_L, CH_LOW_U, CH_LOW_S};
    h1 = tail_hit(w1, needle_r, nlen_r, hlen_r + 7'd1);
    h2 = tail_hit(w2, needle_r, nlen_r, hlen_r + 7'd2);
    h3 = tail_hit(w3, needle_r, nlen_r, hlen_r + 7'd3);
    h4 = tail_hit(w4, needle_r, nlen_r, hlen_r + 7'd4);

    needle_nxt = needle_r;
    win_nxt    = win_r;
    nlen_nxt   = nlen_r;
    hlen_nxt   = hlen_r;
    closed_nxt = closed_r;
    found_nxt  = found_r;
    push       = 1'b0;
    push_match = 1'b0;

    if (item_r.vld && !item_r.hay) begin
      // Needle word: a closed needle starts a new pair
      if (closed_r) begin
        nlen_nxt   = 5'd0;
        hlen_nxt   = 7'd0;
        found_nxt  = 1'b0;
        closed_nxt = 1'b0;
      end
      if (item_r.take && (nlen_nxt < NEEDLE_LIMIT)) begin
        if (item_r.plus) begin
          needle_nxt = {needle_r[WIN-5:0], CH_LOW_P, CH_LOW_L, CH_LOW_U, CH_LOW_S};
          nlen_nxt   = nlen_nxt + 5'd4;
        end else begin
          needle_nxt = {needle_r[WIN-2:0], item_r.chr};
          nlen_nxt   = nlen_nxt + 5'd1;
        end
      end
      if (item_r.last) closed_nxt = 1'b1;
    end else if (item_r.vld) begin
      // Haystack word: shift the window, check every new tail
      if (item_r.take && (hlen_r < HAY_LIMIT)) begin
        if (item_r.plus) begin
          win_nxt   = w4;
          hlen_nxt  = hlen_r + 7'd4;
          found_nxt = found_r || h1 || h2 || h3 || h4;
        end else begin
          win_nxt   = {win_r[WIN-2:0], item_r.chr};
          hlen_nxt  = hlen_r + 7'd1;
          found_nxt = found_r ||
                      tail_hit({win_r[WIN-2:0], item_r.chr}, needle_r, nlen_r, hlen_r + 7'd1);
        end
      end
      if (item_r.last) begin
        push       = 1'b1;
        push_match = found_nxt && (nlen_r != 5'd0) && (hlen_nxt != 7'd0);
        nlen_nxt   = 5'd0;
        hlen_nxt   = 7'd0;
        closed_nxt = 1'b0;
        found_nxt  = 1'b0;
      end
    end
  end

  // Advance the match state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlen_r   <= 5'd0;
      hlen_r   <= 7'd0;
      closed_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      nlen_r   <= nlen_nxt;
      hlen_r   <= hlen_nxt;
      closed_r <= closed_nxt;
      found_r  <= found_nxt;
    end
    needle_r <= needle_nxt;
    win_r    <= win_nxt;
  end

  // Two-entry result buffer: head register plus skid register
  assign pop = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        out_m_r <= sk_m_r;
        sk_v_r  <= push;
        sk_m_r  <= push_match;
      end else begin
        out_v_r <= push;
        out_m_r <= push_match;
      end
    end else if (push) begin
      sk_v_r <= 1'b1;
      sk_m_r <= push_match;
    end
  end

  assign out_valid = out_v_r;
  assign out_match = out_m_r;

endmodule
`default_nettype wire
